// ===== rtl/core/irc_lp_pkg.sv =====
// Shared constants, byte codes and the line summary type of the IRC line parser.
package irc_lp_pkg;

	localparam int LINE_BYTES_DEF = 512;
	localparam int MAX_PARAMS_DEF = 15;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CMD  = 2'd1;
	localparam logic [1:0] ST_NUL      = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [2:0] KIND_NUMERIC = 3'd0;
	localparam logic [2:0] KIND_JOIN    = 3'd1;
	localparam logic [2:0] KIND_MODE    = 3'd2;
	localparam logic [2:0] KIND_NOTICE  = 3'd3;
	localparam logic [2:0] KIND_PRIVMSG = 3'd4;
	localparam logic [2:0] KIND_PING    = 3'd5;
	localparam logic [2:0] KIND_OTHER   = 3'd6;

	// Command names packed right-aligned, first letter in the highest used byte.
	localparam logic [55:0] NAME_JOIN    = 56'h0000_0000_4A4F_494E;
	localparam logic [55:0] NAME_MODE    = 56'h0000_0000_4D4F_4445;
	localparam logic [55:0] NAME_NOTICE  = 56'h0000_4E4F_5449_4345;
	localparam logic [55:0] NAME_PRIVMSG = 56'h0050_5249_564D_5347;
	localparam logic [55:0] NAME_PING    = 56'h0000_0000_5049_4E47;
	localparam logic [3:0]  LEN_JOIN     = 4'd4;
	localparam logic [3:0]  LEN_MODE     = 4'd4;
	localparam logic [3:0]  LEN_NOTICE   = 4'd6;
	localparam logic [3:0]  LEN_PRIVMSG  = 4'd7;
	localparam logic [3:0]  LEN_PING     = 4'd4;

	localparam int DATA_BYTES = 7;

	typedef struct packed {
		logic [8:0] line_length;
		logic [8:0] trailing_offset;
		logic       has_trailing;
		logic       params_saturated;
		logic [3:0] param_count;
		logic [9:0] numeric_code;
		logic [2:0] command_kind;
		logic [8:0] prefix_length;
		logic       has_prefix;
		logic [1:0] status;
	} summary_t;

endpackage

// ===== rtl/core/irc_lp_parser.sv =====
// Per-byte line parse state and the summary produced at each line end or fatal event.
module irc_lp_parser #(
	parameter int LINE_BYTES = irc_lp_pkg::LINE_BYTES_DEF,
	parameter int MAX_PARAMS = irc_lp_pkg::MAX_PARAMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	output logic                  res_valid,
	output irc_lp_pkg::summary_t  res
);

	localparam int LCW = $clog2(LINE_BYTES + 1);
	localparam int PTW = $clog2(MAX_PARAMS + 2);
	localparam logic [PTW-1:0] PT_CAP = PTW'(MAX_PARAMS + 1);
	localparam logic [PTW-1:0] PT_MAX = PTW'(MAX_PARAMS);
	localparam logic [LCW:0]   LB_LIM = (LCW + 1)'(LINE_BYTES);

	typedef enum logic [2:0] {
		PH_CMD_START,
		PH_PREFIX,
		PH_DIGITS,
		PH_ALPHA,
		PH_GAP,
		PH_PARAM,
		PH_TRAILING,
		PH_BAD
	} phase_t;

	typedef struct packed {
		phase_t          phase;
		logic [LCW-1:0]  line_count;
		logic            prefix_flag;
		logic [LCW-1:0]  prefix_bytes;
		logic [55:0]     cmd_text;
		logic [3:0]      cmd_len;
		logic [9:0]      num_val;
		logic [PTW-1:0]  param_total;
		logic            trail_flag;
		logic [LCW-1:0]  trail_start;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		phase: PH_CMD_START, line_count: '0, prefix_flag: 1'b0, prefix_bytes: '0,
		cmd_text: '0, cmd_len: '0, num_val: '0, param_total: '0,
		trail_flag: 1'b0, trail_start: '0
	};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= irc_lp_pkg::CH_DIG0 && c <= irc_lp_pkg::CH_DIG9;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= irc_lp_pkg::CH_UP_A && c <= irc_lp_pkg::CH_UP_Z) ||
			(c >= irc_lp_pkg::CH_LO_A && c <= irc_lp_pkg::CH_LO_Z);
	endfunction

	function automatic line_state_t absorb(input line_state_t s, input logic [7:0] c);
		line_state_t n;
		n = s;
		case (s.phase)
			PH_CMD_START: begin
				if (s.line_count == '0 && c == irc_lp_pkg::CH_COLON) begin
					n.prefix_flag = 1'b1;
					n.phase = PH_PREFIX;
				end else if (s.prefix_flag && c == irc_lp_pkg::CH_SPACE) begin
					n.phase = PH_CMD_START;
				end else if (is_digit(c)) begin
					n.num_val = 10'(c[3:0]);
					n.cmd_len = 4'd1;
					n.phase = PH_DIGITS;
				end else if (is_alpha(c)) begin
					n.cmd_text = 56'(c);
					n.cmd_len = 4'd1;
					n.phase = PH_ALPHA;
				end else begin
					n.phase = PH_BAD;
				end
			end
			PH_PREFIX: begin
				if (c == irc_lp_pkg::CH_SPACE) begin
					n.phase = PH_CMD_START;
				end else begin
					n.prefix_bytes = s.prefix_bytes + 1'b1;
				end
			end
			PH_DIGITS: begin
				if (s.cmd_len < 4'd3) begin
					if (is_digit(c)) begin
						n.num_val = 10'(14'(s.num_val) * 14'd10 + 14'(c[3:0]));
						n.cmd_len = s.cmd_len + 4'd1;
					end else begin
						n.phase = PH_BAD;
					end
				end else begin
					n.phase = (c == irc_lp_pkg::CH_SPACE) ? PH_GAP : PH_BAD;
				end
			end
			PH_ALPHA: begin
				if (is_alpha(c)) begin
					if (s.cmd_len < 4'd7) begin
						n.cmd_text = {s.cmd_text[47:0], c};
					end
					if (s.cmd_len < 4'd8) begin
						n.cmd_len = s.cmd_len + 4'd1;
					end
				end else begin
					n.phase = (c == irc_lp_pkg::CH_SPACE) ? PH_GAP : PH_BAD;
				end
			end
			PH_GAP: begin
				if (c != irc_lp_pkg::CH_SPACE) begin
					if (s.param_total < PT_CAP) begin
						n.param_total = s.param_total + 1'b1;
					end
					if (c == irc_lp_pkg::CH_COLON) begin
						n.trail_flag = 1'b1;
						n.trail_start = s.line_count + 1'b1;
						n.phase = PH_TRAILING;
					end else begin
						n.phase = PH_PARAM;
					end
				end
			end
			PH_PARAM: begin
				if (c == irc_lp_pkg::CH_SPACE) begin
					n.phase = PH_GAP;
				end
			end
			default: begin
				n.phase = s.phase;
			end
		endcase
		n.line_count = s.line_count + 1'b1;
		return n;
	endfunction

	function automatic logic name_is(input line_state_t s, input logic [55:0] name,
			input logic [3:0] len);
		return s.cmd_len == len && s.cmd_text == name;
	endfunction

	line_state_t st_q;
	logic        halted_q;
	logic        pending_cr_q;

	line_state_t st_cr;
	line_state_t st_byte;
	line_state_t st_next;
	logic        pending_next;
	logic        halt_next;
	logic        line_ok;
	logic [2:0]  kind;
	irc_lp_pkg::summary_t fatal_res;
	irc_lp_pkg::summary_t line_res;

	always_comb begin
		line_ok = st_q.phase == PH_ALPHA || st_q.phase == PH_GAP ||
			st_q.phase == PH_PARAM || st_q.phase == PH_TRAILING ||
			(st_q.phase == PH_DIGITS && st_q.cmd_len == 4'd3);

		if (st_q.phase == PH_DIGITS || (st_q.num_val != '0 && st_q.cmd_text == '0) ||
				(st_q.cmd_text == '0 && st_q.cmd_len == 4'd3)) begin
			kind = irc_lp_pkg::KIND_NUMERIC;
		end else if (name_is(st_q, irc_lp_pkg::NAME_JOIN, irc_lp_pkg::LEN_JOIN)) begin
			kind = irc_lp_pkg::KIND_JOIN;
		end else if (name_is(st_q, irc_lp_pkg::NAME_MODE, irc_lp_pkg::LEN_MODE)) begin
			kind = irc_lp_pkg::KIND_MODE;
		end else if (name_is(st_q, irc_lp_pkg::NAME_NOTICE, irc_lp_pkg::LEN_NOTICE)) begin
			kind = irc_lp_pkg::KIND_NOTICE;
		end else if (name_is(st_q, irc_lp_pkg::NAME_PRIVMSG, irc_lp_pkg::LEN_PRIVMSG)) begin
			kind = irc_lp_pkg::KIND_PRIVMSG;
		end else if (name_is(st_q, irc_lp_pkg::NAME_PING, irc_lp_pkg::LEN_PING)) begin
			kind = irc_lp_pkg::KIND_PING;
		end else begin
			kind = irc_lp_pkg::KIND_OTHER;
		end

		line_res = '0;
		line_res.status = irc_lp_pkg::ST_OK;
		line_res.has_prefix = st_q.prefix_flag;
		line_res.prefix_length = 9'(st_q.prefix_bytes);
		line_res.command_kind = kind;
		line_res.numeric_code = (kind == irc_lp_pkg::KIND_NUMERIC) ? st_q.num_val : 10'd0;
		line_res.param_count = (st_q.param_total > PT_MAX) ? 4'(PT_MAX) : 4'(st_q.param_total);
		line_res.params_saturated = st_q.param_total > PT_MAX;
		line_res.has_trailing = st_q.trail_flag;
		line_res.trailing_offset = 9'(st_q.trail_start);
		line_res.line_length = 9'(st_q.line_count);

		st_cr = pending_cr_q ? absorb(st_q, irc_lp_pkg::CH_CR) : st_q;
		st_byte = absorb(st_cr, data_byte);

		st_next = st_q;
		pending_next = pending_cr_q;
		halt_next = 1'b0;
		res_valid = 1'b0;
		fatal_res = '0;
		fatal_res.line_length = 9'(st_q.line_count);
		res = line_res;

		if (data_byte == irc_lp_pkg::CH_NUL) begin
			halt_next = 1'b1;
			res_valid = 1'b1;
			fatal_res.status = irc_lp_pkg::ST_NUL;
			res = fatal_res;
		end else if (pending_cr_q && data_byte == irc_lp_pkg::CH_LF) begin
			pending_next = 1'b0;
			res_valid = 1'b1;
			if (line_ok) begin
				st_next = LINE_CLEAR;
			end else begin
				halt_next = 1'b1;
				fatal_res.status = irc_lp_pkg::ST_BAD_CMD;
				res = fatal_res;
			end
		end else begin
			if (data_byte == irc_lp_pkg::CH_CR) begin
				st_next = st_cr;
				pending_next = 1'b1;
			end else begin
				st_next = st_byte;
				pending_next = 1'b0;
			end
			if ((LCW + 1)'(st_next.line_count) + (LCW + 1)'(pending_next) >= LB_LIM) begin
				halt_next = 1'b1;
				res_valid = 1'b1;
				fatal_res.status = irc_lp_pkg::ST_OVERFLOW;
				fatal_res.line_length = 9'(st_next.line_count);
				res = fatal_res;
			end
		end

		if (halted_q) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_CLEAR;
			halted_q <= 1'b0;
			pending_cr_q <= 1'b0;
		end else if (step && !halted_q) begin
			st_q <= st_next;
			pending_cr_q <= pending_next;
			halted_q <= halt_next;
		end
	end

endmodule

// ===== rtl/core/irc_line_parser.sv =====
// Top level of the IRC line parser: input register, parser and result register.
//
// The slave channel takes one received byte per item on s_axis_tdata. Lines end
// in CR LF; a CR that is not followed by LF counts as an ordinary byte. At each
// line end, and at each fatal event, one summary item leaves on the master
// channel; all other bytes give no item.
// A taken byte is registered in the input register, parsed from there once the result
// register is free, and its summary is registered in the result register for m_axis_tvalid.
// The parse state is updated once per byte, so one byte per cycle
// is accepted for as long as the receiver takes summaries.
// When the receiver stalls, the result register holds its summary and one more
// byte waits in the input register; s_axis_tready then drops.
// A NUL byte, a bad command or a line that fills the buffer gives a fatal
// status; the block then drops every byte and gives no item until reset.
// Reset clears the parse state, the halt flag and both registers' valid flags.
module irc_line_parser #(
	parameter int LINE_BYTES = irc_lp_pkg::LINE_BYTES_DEF,
	parameter int MAX_PARAMS = irc_lp_pkg::MAX_PARAMS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // data_byte
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// status, has_prefix, prefix_length, command_kind, numeric_code, param_count,
	// params_saturated, has_trailing, trailing_offset, line_length, zero fill
	output logic [irc_lp_pkg::DATA_BYTES*8-1:0] m_axis_tdata
);

	localparam int SUM_W = $bits(irc_lp_pkg::summary_t);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 out_free;
	logic                 advance;
	logic                 res_valid;
	irc_lp_pkg::summary_t res;
	irc_lp_pkg::summary_t out_q;
	logic                 out_valid_q;

	assign out_free = !out_valid_q || m_axis_tready;
	assign advance = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	irc_lp_parser #(
		.LINE_BYTES(LINE_BYTES),
		.MAX_PARAMS(MAX_PARAMS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.data_byte(byte_s1),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(irc_lp_pkg::DATA_BYTES * 8 - SUM_W){1'b0}}, out_q};

endmodule
